// ===== hdl/sorted_priority_queue_core_macros.svh =====
// Assertion macros used by the sorted priority queue controller.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/spq_pkg.sv =====
// Types and constants of the sorted priority queue.
package spq_pkg;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned PAY_W = 32;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_PEEK = 2'd2,
    MODE_NOP  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] out_key;
    logic [PAY_W-1:0] out_payload;
    logic             is_empty;
    logic [CNT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== hdl/spq_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
module spq_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/spq_ctrl.sv =====
// Sequencer: ring-buffer pointers, insertion shift and head read.
`include "sorted_priority_queue_core_macros.svh"

module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::req_t     req_i,
  output spq_pkg::mem_req_t mem_o,
  input  spq_pkg::entry_t   rdata_i,
  output logic              rsp_vld_o,
  output spq_pkg::rsp_t     rsp_o
);

  localparam int unsigned IdxW = spq_pkg::IDX_W;
  localparam int unsigned CntW = spq_pkg::CNT_W;
  localparam int unsigned SumW = spq_pkg::CNT_W + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HEAD  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_INS   = 4'b1000
  } state_e;

  function automatic logic [IdxW-1:0] idx_prev(input logic [IdxW-1:0] i);
    return (i == '0) ? IdxW'(spq_pkg::DEPTH - 1) : i - 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] idx_next(input logic [IdxW-1:0] i);
    return (i == IdxW'(spq_pkg::DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] idx_add(input logic [IdxW-1:0] i,
                                              input logic [CntW-1:0] n);
    logic [SumW-1:0] s;
    s = SumW'(i) + SumW'(n);
    if (s >= SumW'(spq_pkg::DEPTH)) begin
      s = s - SumW'(spq_pkg::DEPTH);
    end
    return s[IdxW-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [IdxW-1:0]   head_q, head_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   pos_q, pos_d;
  logic [CntW-1:0]   rem_q, rem_d;
  logic              pop_q, pop_d;
  spq_pkg::entry_t   ent_q, ent_d;
  logic [IdxW-1:0]   tail;

  assign busy = (state_q != S_IDLE);
  assign tail = idx_add(head_q, count_q);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    pos_d     = pos_q;
    rem_d     = rem_q;
    pop_d     = pop_q;
    ent_d     = ent_q;
    mem_o.we    = 1'b0;
    mem_o.waddr = pos_q;
    mem_o.wdata = ent_q;
    mem_o.raddr = head_q;
    rsp_vld_o          = 1'b0;
    rsp_o.status       = spq_pkg::ST_OK;
    rsp_o.out_key      = '0;
    rsp_o.out_payload  = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          ent_d.key     = req_i.key;
          ent_d.payload = req_i.payload;
          case (req_i.mode)
            spq_pkg::MODE_PUSH: begin
              if (count_q == CntW'(spq_pkg::DEPTH)) begin
                rsp_vld_o    = 1'b1;
                rsp_o.status = spq_pkg::ST_FULL;
              end else if (count_q == '0) begin
                mem_o.we            = 1'b1;
                mem_o.waddr         = head_q;
                mem_o.wdata.key     = req_i.key;
                mem_o.wdata.payload = req_i.payload;
                count_d   = count_q + 1'b1;
                rsp_vld_o = 1'b1;
              end else begin
                // walk down from the tail, one compare per cycle
                pos_d       = tail;
                mem_o.raddr = idx_prev(tail);
                rem_d       = count_q;
                state_d     = S_SHIFT;
              end
            end
            spq_pkg::MODE_POP, spq_pkg::MODE_PEEK: begin
              if (count_q == '0) begin
                rsp_vld_o    = 1'b1;
                rsp_o.status = spq_pkg::ST_EMPTY;
              end else begin
                mem_o.raddr = head_q;
                pop_d       = (req_i.mode == spq_pkg::MODE_POP);
                state_d     = S_HEAD;
              end
            end
            default: begin
              rsp_vld_o = 1'b1;
            end
          endcase
        end
      end
      S_HEAD: begin
        rsp_vld_o         = 1'b1;
        rsp_o.out_key     = rdata_i.key;
        rsp_o.out_payload = rdata_i.payload;
        if (pop_q) begin
          head_d  = idx_next(head_q);
          count_d = count_q - 1'b1;
        end
        state_d = S_IDLE;
      end
      S_SHIFT: begin
        mem_o.we = 1'b1;
        if (rdata_i.key > ent_q.key) begin
          // move the larger entry up one slot, fetch the next one down
          mem_o.wdata = rdata_i;
          pos_d       = idx_prev(pos_q);
          rem_d       = rem_q - 1'b1;
          mem_o.raddr = idx_prev(idx_prev(pos_q));
          if (rem_q == CntW'(1)) begin
            state_d = S_INS;
          end
        end else begin
          count_d   = count_q + 1'b1;
          rsp_vld_o = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_INS: begin
        mem_o.we  = 1'b1;
        count_d   = count_q + 1'b1;
        rsp_vld_o = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    rsp_o.is_empty    = (count_d == '0);
    rsp_o.entry_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      pos_q   <= '0;
      rem_q   <= '0;
      pop_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      rem_q   <= rem_d;
      pop_q   <= pop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  `SPQ_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CntW'(spq_pkg::DEPTH),
                  "entry count above depth")
  `SPQ_ASSERT_IMP(a_shift_rem, state_q == S_SHIFT, rem_q != '0,
                  "insertion walk with no entries left")
  `SPQ_ASSERT_IMP(a_rsp_ends, rsp_vld_o, state_d == S_IDLE,
                  "result issued while transaction continues")
  `SPQ_ASSERT_NXT(a_pop_dec, state_q == S_HEAD && pop_q,
                  count_q == $past(count_q) - 1'b1, "pop did not drop the count")

endmodule

// ===== hdl/sorted_priority_queue_core.sv =====
// Top level of the sorted min-priority queue.
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   req_i carries mode (push, pop, peek, or no-op), key and payload.
//   Exactly one result per transaction appears on rsp_o, flagged by done_o
//   for one cycle; the receiver must take it then, it cannot stall.
// Storage:
//   Entries live in one RAM as a ring buffer sorted by key from the head.
//   Equal keys keep arrival order. Pop advances the head pointer.
// Steps from accept to the done_o strobe:
//   - full push, empty pop/peek, no-op, push into an empty queue: answered
//     from the idle state; pop or peek of a non-empty queue: one RAM read
//     of the head; push into a non-empty queue: the single RAM port pair
//     does one compare-and-move per cycle while walking down from the tail
//     past the k stored entries with a larger key, then writes the new entry.
//   busy is high while the sequencer is out of its idle state (head read, walk).
// Reset:
//   Asynchronous, active low; the queue comes up empty, no RAM clear.
module sorted_priority_queue_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::req_t req_i,
  output logic          done_o,
  output spq_pkg::rsp_t rsp_o
);

  spq_pkg::mem_req_t mem_req;
  spq_pkg::entry_t   rdata;
  logic              rsp_vld;
  spq_pkg::rsp_t     rsp_d;
  logic              done_q;
  spq_pkg::rsp_t     rsp_q;

  spq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .req_i     (req_i),
    .mem_o     (mem_req),
    .rdata_i   (rdata),
    .rsp_vld_o (rsp_vld),
    .rsp_o     (rsp_d)
  );

  spq_ram #(
    .Depth (spq_pkg::DEPTH),
    .Width (spq_pkg::KEY_W + spq_pkg::PAY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  // result register: strobe is reset, payload is not
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= rsp_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_vld) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the sorted min-priority queue core.
module tb;

  localparam int unsigned DEPTH = spq_pkg::DEPTH;
  localparam int unsigned KEY_W = spq_pkg::KEY_W;
  localparam int unsigned PAY_W = spq_pkg::PAY_W;
  localparam int unsigned CNT_W = spq_pkg::CNT_W;

  // Run length and watchdog. A push into a nearly full queue can walk every
  // stored entry once, which makes it the slowest transaction.
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned MAX_REPORTS  = 10;

  // One row of the directed table. When hand_checked is set, the expected
  // result is typed in the row; otherwise the queue model supplies it.
  typedef struct {
    spq_pkg::req_t req;
    bit            hand_checked;
    spq_pkg::rsp_t want;
  } dir_row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          start;
  logic          busy;
  spq_pkg::req_t req;
  logic          done;
  spq_pkg::rsp_t rsp;

  // Queue model: entries sorted by key from index 0, ties in arrival order.
  spq_pkg::entry_t model_mem [DEPTH];
  int unsigned     model_count;

  spq_pkg::rsp_t expected_q [$];
  spq_pkg::rsp_t oldest_rsp;
  dir_row_t      directed_rows [$];
  int unsigned   error_count;
  int unsigned   cycle_count;
  int unsigned   random_issued;
  int unsigned   max_gap;

  sorted_priority_queue_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done),
    .rsp_o  (rsp)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Applies one transaction to the model and returns the result it owes.
  function automatic spq_pkg::rsp_t queue_model_step(input spq_pkg::req_t r);
    spq_pkg::rsp_t res;
    int unsigned   pos;
    res        = '0;
    res.status = spq_pkg::ST_OK;
    case (spq_pkg::mode_e'(r.mode))
      spq_pkg::MODE_PUSH: begin
        if (model_count >= DEPTH) begin
          res.status = spq_pkg::ST_FULL;
        end else begin
          // slide larger keys up one slot; equal keys stay ahead
          pos = model_count;
          while (pos > 0 && model_mem[pos-1].key > r.key) begin
            model_mem[pos] = model_mem[pos-1];
            pos--;
          end
          model_mem[pos].key     = r.key;
          model_mem[pos].payload = r.payload;
          model_count++;
        end
      end
      spq_pkg::MODE_POP, spq_pkg::MODE_PEEK: begin
        if (model_count == 0) begin
          res.status = spq_pkg::ST_EMPTY;
        end else begin
          res.out_key     = model_mem[0].key;
          res.out_payload = model_mem[0].payload;
          if (spq_pkg::mode_e'(r.mode) == spq_pkg::MODE_POP) begin
            for (int unsigned i = 1; i < model_count; i++) model_mem[i-1] = model_mem[i];
            model_count--;
          end
        end
      end
      default: ;  // no-op leaves the queue alone
    endcase
    res.is_empty    = (model_count == 0);
    res.entry_count = CNT_W'(model_count);
    return res;
  endfunction

  task automatic add_row(input spq_pkg::mode_e m, input logic [KEY_W-1:0] k,
                         input logic [PAY_W-1:0] p, input bit hand_checked,
                         input spq_pkg::status_e st, input logic [KEY_W-1:0] want_key,
                         input logic [PAY_W-1:0] want_pay, input logic want_empty,
                         input int unsigned want_count);
    dir_row_t row;
    row.req.mode             = m;
    row.req.key              = k;
    row.req.payload          = p;
    row.hand_checked         = hand_checked;
    row.want.status          = st;
    row.want.out_key         = want_key;
    row.want.out_payload     = want_pay;
    row.want.is_empty        = want_empty;
    row.want.entry_count     = CNT_W'(want_count);
    directed_rows.push_back(row);
  endtask

  // Drives one transaction: waits a random gap, raises start at the falling
  // edge, holds until an edge with busy low takes it, then logs the result
  // the queue owes. Returns at the falling edge after the handshake.
  task automatic issue_request(input spq_pkg::req_t r, input bit hand_checked,
                               input spq_pkg::rsp_t typed_rsp);
    int unsigned   gap;
    spq_pkg::rsp_t predicted;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    req   = r;
    do @(posedge clk_i); while (busy);
    predicted = queue_model_step(r);
    expected_q.push_back(hand_checked ? typed_rsp : predicted);
    @(negedge clk_i);
  endtask

  // Keys lean toward a handful of values (zero, all ones, 0 to 7) so that ties are common.
  function automatic logic [KEY_W-1:0] draw_key();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return KEY_W'($urandom_range(0, 7));
      default:    return KEY_W'($urandom());
    endcase
  endfunction

  task automatic issue_random(input int unsigned push_pct, input int unsigned pop_pct);
    spq_pkg::req_t r;
    spq_pkg::rsp_t unused;
    int unsigned   pick;
    pick = $urandom_range(0, 99);
    if (pick < push_pct)                r.mode = spq_pkg::MODE_PUSH;
    else if (pick < push_pct + pop_pct) r.mode = spq_pkg::MODE_POP;
    else if (pick < 97)                 r.mode = spq_pkg::MODE_PEEK;
    else                                r.mode = spq_pkg::MODE_NOP;
    r.key     = draw_key();
    r.payload = PAY_W'($urandom());
    unused    = '0;
    issue_request(r, 1'b0, unused);
    random_issued++;
  endtask

  // Sender holds off until every outstanding result has come back.
  task automatic hold_until_drained();
    start = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  // Result checker: the strobe lasts one cycle and cannot be stalled, so
  // every edge with done high is a transaction to match against the oldest
  // expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done) begin
      if (expected_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("tb: unexpected result at cycle %0d: st=%0d key=%h pay=%h empty=%0b cnt=%0d",
                   cycle_count, rsp.status, rsp.out_key, rsp.out_payload, rsp.is_empty,
                   rsp.entry_count);
      end else begin
        oldest_rsp = expected_q.pop_front();
        if (rsp.status !== oldest_rsp.status || rsp.out_key !== oldest_rsp.out_key ||
            rsp.out_payload !== oldest_rsp.out_payload ||
            rsp.is_empty !== oldest_rsp.is_empty ||
            rsp.entry_count !== oldest_rsp.entry_count) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("tb: mismatch at cycle %0d", cycle_count);
            $display("  expected st=%0d key=%h pay=%h empty=%0b cnt=%0d",
                     oldest_rsp.status, oldest_rsp.out_key, oldest_rsp.out_payload,
                     oldest_rsp.is_empty, oldest_rsp.entry_count);
            $display("  actual   st=%0d key=%h pay=%h empty=%0b cnt=%0d",
                     rsp.status, rsp.out_key, rsp.out_payload, rsp.is_empty,
                     rsp.entry_count);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni        = 1'b0;
    start         = 1'b0;
    req           = '0;
    model_count   = 0;
    error_count   = 0;
    cycle_count   = 0;
    random_issued = 0;
    max_gap       = 12;

    // Directed table: empty-queue errors, no-op, key extremes, a run of
    // equal keys that must leave in arrival order, then a full drain.
    add_row(spq_pkg::MODE_POP,  '0, '0, 1'b1, spq_pkg::ST_EMPTY, '0, '0, 1'b1, 0);
    add_row(spq_pkg::MODE_PEEK, 32'h1234_5678, 32'h9abc_def0, 1'b1, spq_pkg::ST_EMPTY,
            '0, '0, 1'b1, 0);
    add_row(spq_pkg::MODE_NOP,  32'hdead_beef, 32'hcafe_f00d, 1'b1, spq_pkg::ST_OK,
            '0, '0, 1'b1, 0);
    add_row(spq_pkg::MODE_PUSH, '1, '1, 1'b1, spq_pkg::ST_OK, '0, '0, 1'b0, 1);
    add_row(spq_pkg::MODE_PEEK, '0, '0, 1'b1, spq_pkg::ST_OK, '1, '1, 1'b0, 1);
    add_row(spq_pkg::MODE_PUSH, '0, '0, 1'b1, spq_pkg::ST_OK, '0, '0, 1'b0, 2);
    add_row(spq_pkg::MODE_PEEK, '0, '0, 1'b1, spq_pkg::ST_OK, '0, '0, 1'b0, 2);
    add_row(spq_pkg::MODE_PUSH, 32'd5, 32'h0000_00a1, 1'b0, spq_pkg::ST_OK, '0, '0, 1'b0, 0);
    add_row(spq_pkg::MODE_PUSH, 32'd5, 32'h0000_00a2, 1'b0, spq_pkg::ST_OK, '0, '0, 1'b0, 0);
    add_row(spq_pkg::MODE_PUSH, 32'd5, 32'h0000_00a3, 1'b0, spq_pkg::ST_OK, '0, '0, 1'b0, 0);
    add_row(spq_pkg::MODE_PUSH, 32'h8000_0000, 32'h5555_5555, 1'b0, spq_pkg::ST_OK,
            '0, '0, 1'b0, 0);
    add_row(spq_pkg::MODE_PUSH, 32'd1, 32'haaaa_aaaa, 1'b0, spq_pkg::ST_OK, '0, '0, 1'b0, 0);
    add_row(spq_pkg::MODE_NOP,  32'h0f0f_0f0f, 32'hf0f0_f0f0, 1'b0, spq_pkg::ST_OK,
            '0, '0, 1'b0, 0);
    add_row(spq_pkg::MODE_PEEK, '1, '1, 1'b0, spq_pkg::ST_OK, '0, '0, 1'b0, 0);
    repeat (7) add_row(spq_pkg::MODE_POP, 32'h0000_0003, 32'h7777_7777, 1'b0,
                       spq_pkg::ST_OK, '0, '0, 1'b0, 0);
    add_row(spq_pkg::MODE_POP,  '0, '0, 1'b1, spq_pkg::ST_EMPTY, '0, '0, 1'b1, 0);
    add_row(spq_pkg::MODE_NOP,  '0, '0, 1'b1, spq_pkg::ST_OK, '0, '0, 1'b1, 0);

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      issue_request(directed_rows[i].req, directed_rows[i].hand_checked, directed_rows[i].want);
    hold_until_drained();

    // Mixed traffic around a shallow queue.
    repeat (60) issue_random(45, 30);
    hold_until_drained();

    // Fill to capacity, then knock on the full queue.
    while (model_count < DEPTH) issue_random(96, 2);
    repeat (12) issue_random(90, 4);
    hold_until_drained();

    // Drain to empty, then keep popping into the empty queue.
    while (model_count > 0) issue_random(2, 96);
    repeat (8) issue_random(6, 84);
    hold_until_drained();

    // Mixed tail.
    do issue_random(45, 30); while (random_issued < RANDOM_ITEMS);

    hold_until_drained();
    repeat (DEPTH + 8) @(posedge clk_i);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
